// ===== rtl/core/sensor_packet_deframer_crc8_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet deframer
// Shorthand for clocked, reset-qualified concurrent assertions. The using
// scope must provide clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef SENSOR_PACKET_DEFRAMER_CRC8_MACROS_SVH
`define SENSOR_PACKET_DEFRAMER_CRC8_MACROS_SVH

// Same-cycle implication.
`define SPDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/spdc_pkg.sv =====
// ----------------------------------------------------------------------------
// spdc_pkg
// Shared widths, header constants, register indexes, control structs and the
// CRC-8 byte update for the packet deframer.
// ----------------------------------------------------------------------------
package spdc_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned ID_W            = 2;
  localparam int unsigned LEN_W           = 6;
  localparam int unsigned POS_W           = 5;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned MAX_PAYLOAD_DEF = 32;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hA5;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h5A;
  localparam logic [BYTE_W-1:0] ID_LIMIT   = 8'h03;

  localparam logic [CFG_IDX_W-1:0] CFG_POLY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN = 1'b1;

  localparam logic [BYTE_W-1:0] POLY_RST   = 8'h07;
  localparam logic [LEN_W-1:0]  MAXLEN_RST = 6'd32;

  // Payload memory write request
  typedef struct packed {
    logic              en;
    logic [LEN_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } spdc_wr_t;

  // Readout start request
  typedef struct packed {
    logic             go;
    logic [ID_W-1:0]  sensor;
    logic [LEN_W-1:0] length;
  } spdc_start_t;

  typedef struct packed {
    logic [ID_W-1:0]  sensor;
    logic [LEN_W-1:0] length;
    logic [POS_W-1:0] position;
    logic             last;
  } spdc_meta_t;

  typedef struct packed {
    spdc_meta_t        meta;
    logic [BYTE_W-1:0] value;
  } spdc_result_t;

  // MSB-first CRC-8 update over one byte, no reflection
  function automatic logic [BYTE_W-1:0] crc8_add(input logic [BYTE_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [BYTE_W-1:0] poly);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/spdc_readout.sv =====
// ----------------------------------------------------------------------------
// spdc_readout
// Payload memory with one write and one registered read port, plus the
// sequencer that streams a checked packet out one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module spdc_readout #(
  parameter int unsigned MAX_PAYLOAD = spdc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spdc_pkg::spdc_wr_t    wr,
  input  spdc_pkg::spdc_start_t start,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output spdc_pkg::spdc_result_t out_res
);
  import spdc_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] mem_q_r;

  logic             busy_r, busy_nxt;
  logic [LEN_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [LEN_W-1:0] rd_len_r, rd_len_nxt;
  logic [ID_W-1:0]  rd_sensor_r, rd_sensor_nxt;
  logic             pend_r, pend_nxt;
  spdc_meta_t       pend_meta_r, pend_meta_nxt;
  logic             out_valid_r, out_valid_nxt;
  spdc_result_t     out_res_r, out_res_nxt;

  logic             load_out;
  logic             issue;
  logic [LEN_W-1:0] rd_idx_inc;
  logic             rd_last;

  assign load_out   = pend_r && (!out_valid_r || out_ready);
  assign issue      = busy_r && (!pend_r || load_out);
  assign rd_idx_inc = rd_idx_r + 1'b1;
  assign rd_last    = (rd_idx_inc == rd_len_r);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (issue) begin
      mem_q_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    rd_idx_nxt    = rd_idx_r;
    rd_len_nxt    = rd_len_r;
    rd_sensor_nxt = rd_sensor_r;
    pend_nxt      = pend_r;
    pend_meta_nxt = pend_meta_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    if (start.go) begin
      busy_nxt      = 1'b1;
      rd_idx_nxt    = '0;
      rd_len_nxt    = start.length;
      rd_sensor_nxt = start.sensor;
    end else if (issue) begin
      rd_idx_nxt = rd_idx_inc;
      if (rd_last) begin
        busy_nxt = 1'b0;
      end
    end

    if (issue) begin
      pend_nxt               = 1'b1;
      pend_meta_nxt.sensor   = rd_sensor_r;
      pend_meta_nxt.length   = rd_len_r;
      pend_meta_nxt.position = rd_idx_r[POS_W-1:0];
      pend_meta_nxt.last     = rd_last;
    end else if (load_out) begin
      pend_nxt = 1'b0;
    end

    if (load_out) begin
      out_valid_nxt     = 1'b1;
      out_res_nxt.meta  = pend_meta_r;
      out_res_nxt.value = mem_q_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_len_r    <= rd_len_nxt;
    rd_sensor_r <= rd_sensor_nxt;
    pend_meta_r <= pend_meta_nxt;
    out_res_r   <= out_res_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== rtl/core/sensor_packet_deframer_crc8.sv =====
// Input: one byte word per cycle while not streaming out a packet.
// A matching CRC byte starts a readout of N payload words (N = length),
// each read through the payload memory's single read port into a read
// register, then loaded into the output register, one word per cycle while
// out_ready holds. in_ready stays low until the last word's read issues.
// Synchronous active-low reset: hunt for header, CRC 0, registers to reset.
// ----------------------------------------------------------------------------
// sensor_packet_deframer_crc8
// Header-hunting packet deframer with a programmable CRC-8 check. Buffers
// the payload in a small memory and releases it only on a good CRC.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_crc8 #(
  parameter int unsigned MAX_PAYLOAD = spdc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // byte input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [spdc_pkg::BYTE_W-1:0]     in_data_byte,
  // payload result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [spdc_pkg::ID_W-1:0]       out_sensor_number,
  output logic [spdc_pkg::LEN_W-1:0]      out_packet_length,
  output logic [spdc_pkg::BYTE_W-1:0]     out_payload_value,
  output logic [spdc_pkg::POS_W-1:0]      out_byte_position,
  output logic                            out_last_of_packet,
  // register writes
  input  logic                            cfg_wr_en,
  input  logic [spdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spdc_pkg::BYTE_W-1:0]     cfg_data
);
  import spdc_pkg::*;

  // Frame phases, one-hot
  typedef enum logic [5:0] {
    PH_HDR1  = 6'b000001,
    PH_HDR2  = 6'b000010,
    PH_ID    = 6'b000100,
    PH_LEN   = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_CHECK = 6'b100000
  } spdc_phase_t;

  localparam logic [LEN_W:0] MAX_P = (LEN_W+1)'(MAX_PAYLOAD);

  spdc_phase_t       phase_r, phase_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [ID_W-1:0]   sensor_r, sensor_nxt;
  logic [BYTE_W-1:0] poly_r;
  logic [LEN_W-1:0]  maxlen_r;

  logic              in_fire;
  logic              rd_busy;
  logic [BYTE_W-1:0] crc_cont;
  logic [BYTE_W-1:0] crc_seed;
  logic [LEN_W:0]    len_limit;
  logic [LEN_W-1:0]  fill_inc;
  spdc_wr_t          wr;
  spdc_start_t       start;
  spdc_result_t      res;

  // Hold off new bytes while the readout is still issuing memory reads.
  assign in_ready = !rd_busy;
  assign in_fire  = in_valid && in_ready;

  assign crc_cont = crc8_add(crc_r, in_data_byte, poly_r);
  assign crc_seed = crc8_add('0, in_data_byte, poly_r);
  assign fill_inc = fill_r + 1'b1;

  // Accepted length ceiling: the smaller of the register and the buffer depth.
  assign len_limit = ({1'b0, maxlen_r} < MAX_P) ? {1'b0, maxlen_r} : MAX_P;

  always_comb begin
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    sensor_nxt = sensor_r;
    wr         = '0;
    start      = '0;

    if (in_fire) begin
      unique case (phase_r)
        PH_HDR1: begin
          if (in_data_byte == HDR_FIRST) begin
            fill_nxt  = '0;
            crc_nxt   = crc_seed;
            phase_nxt = PH_HDR2;
          end
        end
        PH_HDR2: begin
          // A repeated first header byte restarts the sync over itself.
          if (in_data_byte == HDR_SECOND) begin
            crc_nxt   = crc_cont;
            phase_nxt = PH_ID;
          end else if (in_data_byte == HDR_FIRST) begin
            crc_nxt = crc_seed;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_ID: begin
          if (in_data_byte <= ID_LIMIT) begin
            sensor_nxt = in_data_byte[ID_W-1:0];
            crc_nxt    = crc_cont;
            phase_nxt  = PH_LEN;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_LEN: begin
          if (in_data_byte != '0 && in_data_byte <= {1'b0, len_limit}) begin
            len_nxt   = in_data_byte[LEN_W-1:0];
            crc_nxt   = crc_cont;
            fill_nxt  = '0;
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_DATA: begin
          // Store the payload word and advance the fill pointer.
          wr.en     = 1'b1;
          wr.addr   = fill_r;
          wr.data   = in_data_byte;
          fill_nxt  = fill_inc;
          crc_nxt   = crc_cont;
          if (fill_inc >= len_r) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          // Release the buffered packet on a match, drop it silently otherwise.
          phase_nxt = PH_HDR1;
          fill_nxt  = '0;
          if (in_data_byte == crc_r) begin
            start.go     = 1'b1;
            start.sensor = sensor_r;
            start.length = len_r;
          end
        end
        default: begin
          phase_nxt = PH_HDR1;
          crc_nxt   = '0;
          fill_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR1;
      crc_r    <= '0;
      fill_r   <= '0;
      len_r    <= '0;
      sensor_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      crc_r    <= crc_nxt;
      fill_r   <= fill_nxt;
      len_r    <= len_nxt;
      sensor_r <= sensor_nxt;
    end
  end

  // Register file: polynomial and length ceiling, write-only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r   <= POLY_RST;
      maxlen_r <= MAXLEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_POLY:   poly_r   <= cfg_data;
        CFG_MAXLEN: maxlen_r <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

  spdc_readout #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_readout (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .start    (start),
    .busy     (rd_busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (res)
  );

  assign out_sensor_number  = res.meta.sensor;
  assign out_packet_length  = res.meta.length;
  assign out_payload_value  = res.value;
  assign out_byte_position  = res.meta.position;
  assign out_last_of_packet = res.meta.last;

endmodule

// ===== rtl/core/spdc_checker.sv =====
// ----------------------------------------------------------------------------
// spdc_checker
// Port-level checks on the deframer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "sensor_packet_deframer_crc8_macros.svh"

module spdc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [spdc_pkg::BYTE_W-1:0]     in_data_byte,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [spdc_pkg::ID_W-1:0]       out_sensor_number,
  input logic [spdc_pkg::LEN_W-1:0]      out_packet_length,
  input logic [spdc_pkg::BYTE_W-1:0]     out_payload_value,
  input logic [spdc_pkg::POS_W-1:0]      out_byte_position,
  input logic                            out_last_of_packet
);
  import spdc_pkg::*;

  // A waiting byte word holds until it is taken.
  `SPDC_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data_byte), "byte word changed while waiting")

  // A stalled result word holds its value, position and last flag.
  `SPDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload_value) && $stable(out_byte_position) && $stable(out_last_of_packet), "result word changed while stalled")

  // The last word of a run sits at the final position of its packet.
  `SPDC_ASSERT_NOW(a_last_pos, out_valid && out_last_of_packet, out_byte_position == (out_packet_length[POS_W-1:0] - 5'd1), "last flag off the final position")

  // Positions stay inside the packet length.
  `SPDC_ASSERT_NOW(a_pos_range, out_valid, out_packet_length != '0 && {1'b0, out_byte_position} < out_packet_length, "byte position beyond packet length")

  // A run continues in order with the same packet fields.
  `SPDC_ASSERT_NEXT(a_run_order, out_valid && out_ready && !out_last_of_packet, !out_valid || (out_packet_length == $past(out_packet_length) && out_sensor_number == $past(out_sensor_number) && out_byte_position == 5'($past(out_byte_position) + 5'd1)), "result run out of order")

endmodule

bind sensor_packet_deframer_crc8 spdc_checker u_spdc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_data_byte      (in_data_byte),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_sensor_number (out_sensor_number),
  .out_packet_length (out_packet_length),
  .out_payload_value (out_payload_value),
  .out_byte_position (out_byte_position),
  .out_last_of_packet(out_last_of_packet)
);
